/* hdl/bdc_pkg.sv */
`timescale 1ns / 1ps

package bdc_pkg;

   localparam int DAY_W     = 5;
   localparam int MONTH_W   = 4;
   localparam int YEAR_W    = 14;
   localparam int COUNT_W   = 22;
   localparam int WDAY_W    = 3;
   localparam int MASK_W    = 7;
   localparam int CENT_W    = 7;
   localparam int REQ_W     = 48;
   localparam int RSP_W     = 24;

   localparam logic [MASK_W-1:0]  MASK_RESET = 7'd96;
   localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
   localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_MIN  = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_MAX  = 4'd12;
   localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
   localparam logic [DAY_W-1:0]   DAY_MIN    = 5'd1;
   localparam logic [COUNT_W-1:0] COUNT_MAX  = 22'd4194303;

   // y / 100 as (y * 5243) >> 19, exact for every y below 43690
   localparam logic [12:0] RECIP_100   = 13'd5243;
   localparam int          RECIP_SHIFT = 19;
   localparam logic [6:0]  CENT_YEARS  = 7'd100;

   // serial day 0 is a wednesday
   localparam logic [COUNT_W-1:0] SERIAL_WDAY = 22'd3;

   localparam logic [WDAY_W-1:0] DIVISOR  = 3'd7;

   // x / 7 as (x * 4793491) >> 25, exact for every x up to 6710886
   localparam logic [22:0] RECIP_7       = 23'd4793491;
   localparam int          RECIP_7_SHIFT = 25;
   localparam int          PROD_W        = COUNT_W + 23;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_YEAR,
      ST_CENT_Y,
      ST_DAY,
      ST_CENT_S,
      ST_SERIAL,
      ST_CMP,
      ST_WDAY_GO,
      ST_WDAY_WAIT,
      ST_SPAN_GO,
      ST_SPAN_WAIT,
      ST_MUL,
      ST_REM,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic load_req;
      logic sel_end;
      logic clamp;
      logic cent;
      logic cent_of_shift;
      logic day;
      logic serial;
      logic cmp;
      logic div_start;
      logic div_span;
      logic load_wday;
      logic mul;
      logic rem_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic lt;
      logic div_busy;
      logic rem_zero;
   } sts_type;

   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] d;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
         4'd2:                                       d = leap ? 5'd29 : 5'd28;
         default:                                    d = 5'd31;
      endcase
      return d;
   endfunction

   // days before the start of a month counted from march
   function automatic logic [8:0] month_offset(input logic [MONTH_W-1:0] mp);
      logic [8:0] o;
      unique case (mp)
         4'd0:    o = 9'd0;
         4'd1:    o = 9'd31;
         4'd2:    o = 9'd61;
         4'd3:    o = 9'd92;
         4'd4:    o = 9'd122;
         4'd5:    o = 9'd153;
         4'd6:    o = 9'd184;
         4'd7:    o = 9'd214;
         4'd8:    o = 9'd245;
         4'd9:    o = 9'd275;
         4'd10:   o = 9'd306;
         4'd11:   o = 9'd337;
         default: o = 9'd0;
      endcase
      return o;
   endfunction

endpackage

/* hdl/bdc_divider.sv */
`timescale 1ns / 1ps

module bdc_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   input  logic [bdc_pkg::COUNT_W-1:0]  dividend,
   output logic [bdc_pkg::COUNT_W-1:0]  quotient,
   output logic [bdc_pkg::WDAY_W-1:0]   remainder,
   output logic                         busy
);
   import bdc_pkg::*;

   logic [COUNT_W-1:0]  x_ff, x_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [COUNT_W-1:0]  quo_ff, quo_in;
   logic [WDAY_W-1:0]   rem_ff, rem_in;
   logic                phase_ff, phase_in;
   logic                busy_ff, busy_in;
   logic [COUNT_W-1:0]  quo_next;
   logic [COUNT_W+2:0]  quo_times;

   // divide by seven through the reciprocal: product first, then quotient and remainder
   assign quo_next  = COUNT_W'(prod_ff[PROD_W-1:RECIP_7_SHIFT]);
   assign quo_times = (COUNT_W+3)'(quo_next) * (COUNT_W+3)'(DIVISOR);

   always_comb begin
      x_in     = x_ff;
      prod_in  = prod_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      phase_in = phase_ff;
      busy_in  = busy_ff;
      if (start) begin
         x_in     = dividend;
         phase_in = 1'b0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         if (!phase_ff) begin
            prod_in  = PROD_W'(x_ff) * PROD_W'(RECIP_7);
            phase_in = 1'b1;
         end else begin
            quo_in  = quo_next;
            rem_in  = WDAY_W'((COUNT_W+3)'(x_ff) - quo_times);
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         phase_ff <= phase_in;
      end
      x_ff    <= x_in;
      prod_ff <= prod_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign quotient  = quo_ff;
   assign remainder = rem_ff;
   assign busy      = busy_ff;

endmodule

/* hdl/bdc_datapath.sv */
`timescale 1ns / 1ps

module bdc_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  bdc_pkg::cmd_type             cmd,
   output bdc_pkg::sts_type             sts,
   input  logic [bdc_pkg::REQ_W-1:0]    req_tdata,
   output logic [bdc_pkg::RSP_W-1:0]    rsp_tdata,
   input  logic                         csr_write,
   input  logic [bdc_pkg::MASK_W-1:0]   csr_data
);
   import bdc_pkg::*;

   logic [MASK_W-1:0]  mask_ff;
   logic [DAY_W-1:0]   sd_ff, ed_ff;
   logic [MONTH_W-1:0] sm_ff, em_ff;
   logic [YEAR_W-1:0]  sy_ff, ey_ff;

   logic [YEAR_W-1:0]  yc_ff, yc_in;
   logic [MONTH_W-1:0] mc_ff, mc_in;
   logic [CENT_W-1:0]  q_ff;
   logic [DAY_W-1:0]   dc_ff, dc_in;
   logic [YEAR_W-1:0]  yy_ff;
   logic [MONTH_W-1:0] mp_ff;
   logic [COUNT_W-1:0] s0_ff, s1_ff, serial_val;
   logic [WDAY_W-1:0]  wd_ff, rem_ff;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] rsp_ff;

   logic [DAY_W-1:0]   d_raw, lim;
   logic [MONTH_W-1:0] m_raw;
   logic [YEAR_W-1:0]  y_raw, cent_src;
   logic [26:0]        cent_prod;
   logic               is_cent, leap;
   logic [COUNT_W-1:0] div_dividend, div_quo;
   logic [WDAY_W-1:0]  div_rem, per_week;
   logic               div_busy;
   logic [COUNT_W+2:0] week_prod;

   bdc_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (cmd.div_start),
      .dividend  (div_dividend),
      .quotient  (div_quo),
      .remainder (div_rem),
      .busy      (div_busy)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= MASK_RESET;
      end else if (csr_write) begin
         mask_ff <= csr_data;
      end
   end

   assign d_raw = cmd.sel_end ? ed_ff : sd_ff;
   assign m_raw = cmd.sel_end ? em_ff : sm_ff;
   assign y_raw = cmd.sel_end ? ey_ff : sy_ff;

   always_comb begin
      yc_in = y_raw;
      if (y_raw < YEAR_MIN) yc_in = YEAR_MIN;
      if (y_raw > YEAR_MAX) yc_in = YEAR_MAX;
      mc_in = m_raw;
      if (m_raw < MONTH_MIN) mc_in = MONTH_MIN;
      if (m_raw > MONTH_MAX) mc_in = MONTH_MAX;
   end

   assign cent_src  = cmd.cent_of_shift ? yy_ff : yc_ff;
   assign cent_prod = 27'(cent_src) * 27'(RECIP_100);

   // leap: divisible by four, and a century year only when its century count is too
   assign is_cent = (yc_ff == YEAR_W'(q_ff * CENT_YEARS));
   assign leap    = (yc_ff[1:0] == 2'd0) && (!is_cent || q_ff[1:0] == 2'd0);
   assign lim     = month_days(mc_ff, leap);

   always_comb begin
      dc_in = d_raw;
      if (d_raw < DAY_MIN) dc_in = DAY_MIN;
      if (d_raw > lim)     dc_in = lim;
   end

   assign serial_val = COUNT_W'(yy_ff) * 22'd365 + COUNT_W'(yy_ff >> 2)
                     - COUNT_W'(q_ff) + COUNT_W'(q_ff >> 2)
                     + COUNT_W'(month_offset(mp_ff)) + COUNT_W'(dc_ff) - 22'd1;

   assign div_dividend = cmd.div_span ? (s1_ff - s0_ff) : (s0_ff + SERIAL_WDAY);
   assign per_week     = WDAY_W'($countones(~mask_ff));
   assign week_prod    = (COUNT_W+3)'(div_quo) * (COUNT_W+3)'(per_week);

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         sd_ff <= req_tdata[4:0];
         sm_ff <= req_tdata[8:5];
         sy_ff <= req_tdata[22:9];
         ed_ff <= req_tdata[27:23];
         em_ff <= req_tdata[31:28];
         ey_ff <= req_tdata[45:32];
      end
      if (cmd.clamp) begin
         yc_ff <= yc_in;
         mc_ff <= mc_in;
      end
      if (cmd.cent) begin
         q_ff <= cent_prod[RECIP_SHIFT +: CENT_W];
      end
      if (cmd.day) begin
         dc_ff <= dc_in;
         yy_ff <= (mc_ff <= MONTH_FEB) ? yc_ff - 14'd1 : yc_ff;
         mp_ff <= (mc_ff > MONTH_FEB) ? mc_ff - 4'd3 : mc_ff + 4'd9;
      end
      if (cmd.serial) begin
         if (cmd.sel_end) begin
            s1_ff <= serial_val;
         end else begin
            s0_ff <= serial_val;
         end
      end
      if (cmd.load_wday) begin
         wd_ff <= div_rem;
      end
      if (cmd.cmp) begin
         count_ff <= '0;
      end else if (cmd.mul) begin
         count_ff <= (week_prod > (COUNT_W+3)'(COUNT_MAX)) ? COUNT_MAX
                                                          : week_prod[COUNT_W-1:0];
         rem_ff   <= div_rem;
      end else if (cmd.rem_step) begin
         if (!mask_ff[wd_ff] && count_ff != COUNT_MAX) begin
            count_ff <= count_ff + 22'd1;
         end
         wd_ff  <= (wd_ff == 3'd6) ? 3'd0 : wd_ff + 3'd1;
         rem_ff <= rem_ff - 3'd1;
      end
      if (cmd.load_rsp) begin
         rsp_ff <= count_ff;
      end
   end

   assign sts.lt       = (s0_ff < s1_ff);
   assign sts.div_busy = div_busy;
   assign sts.rem_zero = (rem_ff == '0);

   assign rsp_tdata = {2'b00, rsp_ff};

endmodule

/* hdl/bdc_controller.sv */
`timescale 1ns / 1ps

module bdc_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  bdc_pkg::sts_type  sts,
   output bdc_pkg::cmd_type  cmd
);
   import bdc_pkg::*;

   state_type state_ff, state_in;
   logic      sel_ff, sel_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_YEAR;
               sel_in   = 1'b0;
            end
         end
         ST_YEAR:   state_in = ST_CENT_Y;
         ST_CENT_Y: state_in = ST_DAY;
         ST_DAY:    state_in = ST_CENT_S;
         ST_CENT_S: state_in = ST_SERIAL;
         ST_SERIAL: begin
            if (sel_ff) begin
               state_in = ST_CMP;
            end else begin
               state_in = ST_YEAR;
               sel_in   = 1'b1;
            end
         end
         ST_CMP:       state_in = sts.lt ? ST_WDAY_GO : ST_OUT;
         ST_WDAY_GO:   state_in = ST_WDAY_WAIT;
         ST_WDAY_WAIT: if (!sts.div_busy) state_in = ST_SPAN_GO;
         ST_SPAN_GO:   state_in = ST_SPAN_WAIT;
         ST_SPAN_WAIT: if (!sts.div_busy) state_in = ST_MUL;
         ST_MUL:       state_in = ST_REM;
         ST_REM:       if (sts.rem_zero) state_in = ST_OUT;
         ST_OUT:       if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd            = '0;
      cmd.sel_end    = sel_ff;
      req_tready     = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready   = 1'b1;
            cmd.load_req = req_tvalid;
         end
         ST_YEAR:   cmd.clamp = 1'b1;
         ST_CENT_Y: cmd.cent = 1'b1;
         ST_DAY:    cmd.day = 1'b1;
         ST_CENT_S: begin
            cmd.cent          = 1'b1;
            cmd.cent_of_shift = 1'b1;
         end
         ST_SERIAL:    cmd.serial = 1'b1;
         ST_CMP:       cmd.cmp = 1'b1;
         ST_WDAY_GO:   cmd.div_start = 1'b1;
         ST_WDAY_WAIT: cmd.load_wday = !sts.div_busy;
         ST_SPAN_GO: begin
            cmd.div_start = 1'b1;
            cmd.div_span  = 1'b1;
         end
         ST_SPAN_WAIT: cmd.div_span = 1'b1;
         ST_MUL:       cmd.mul = 1'b1;
         ST_REM:       cmd.rem_step = !sts.rem_zero;
         ST_OUT:       cmd.load_rsp = out_free;
         default:      cmd = '0;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sel_ff       <= sel_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;

endmodule

/* hdl/business_day_counter_unit.sv */
// when start is not before end, no divide or part-week step runs before rsp_tvalid;
// otherwise the time from item acceptance to rsp_tvalid is set by two passes of the reciprocal divide by seven
// plus up to six single-day steps for the part week
// the unit works on one item at a time; a new item is taken while a result waits
// reset clears the controller, the divider and the result valid, and sets the weekend mask to 96
`timescale 1ns / 1ps

module business_day_counter_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // start_day, start_month, start_year, end_day, end_month, end_year, zero pad
   input  logic [bdc_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // business_days, zero pad
   output logic [bdc_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [bdc_pkg::MASK_W-1:0]  csr_data
);
   import bdc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   assign csr_ready = 1'b1;

   bdc_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   bdc_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data)
   );

   // the divider is idle whenever a new item can be taken
   a_idle_div: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !sts.div_busy)
      else $error("divider busy while accepting an item");

   // a divide is never launched over one still running
   a_div_start: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !sts.div_busy)
      else $error("divider restarted while busy");

   // a result is only loaded into a free output register
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_tvalid || rsp_tready))
      else $error("result overwritten before it was taken");

   // an accepted item closes the input until its result is loaded
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second item accepted while one is in work");

endmodule

/* tb/tb_business_day_counter_unit.sv */
`timescale 1ns / 1ps

module tb_business_day_counter_unit;
   import bdc_pkg::*;

   localparam int LONG_HOLD   = 400;
   localparam int SETTLE      = 100;
   localparam int RUN_LIMIT   = 40_000_000;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
   } raw_date_type;

   // first date in the low bits, as on req_tdata
   typedef struct packed {
      raw_date_type finish_date;
      raw_date_type first_date;
   } date_pair_type;

   logic               clock      = 1'b0;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;
   logic               csr_valid  = 1'b0;
   logic               csr_ready;
   logic [MASK_W-1:0]  csr_data   = '0;

   logic [MASK_W-1:0]  weekend_bits = MASK_RESET;
   logic [COUNT_W-1:0] pending_counts[$];
   int                 mismatch_count = 0;
   bit                 idling_on = 1'b1;

   int hold_left   = 0;
   int stall_left  = 0;
   int holds_taken = 0;
   int holds_asked = 0;
   int rsp_gap;

   business_day_counter_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   // ---------------------------------------------------------------- calendar

   function automatic int month_length(input int m, input int y);
      bit leap_year;
      leap_year = (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
      case (m)
         2:           return leap_year ? 29 : 28;
         4, 6, 9, 11: return 30;
         default:     return 31;
      endcase
   endfunction

   function automatic void clamp_date(input raw_date_type r, output int d, output int m,
                                      output int y);
      int lim;
      y = r.year;
      m = r.month;
      d = r.day;
      if (y < 1) y = 1;
      if (y > 9999) y = 9999;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      lim = month_length(m, y);
      if (d < 1) d = 1;
      if (d > lim) d = lim;
   endfunction

   // days counted from a march-based year, only differences matter
   function automatic int day_number(input int d, input int m, input int y);
      int yy;
      int mp;
      yy = (m <= 2) ? y - 1 : y;
      mp = (m > 2) ? m - 3 : m + 9;
      return 365 * yy + yy / 4 - yy / 100 + yy / 400 + (153 * mp + 2) / 5 + d - 1;
   endfunction

   // 0 is sunday
   function automatic int weekday_of(input int d, input int m, input int y);
      int a;
      int yy;
      int mm;
      a  = (14 - m) / 12;
      yy = y - a;
      mm = m + 12 * a - 2;
      return (d + yy + yy / 4 - yy / 100 + yy / 400 + (31 * mm) / 12) % 7;
   endfunction

   function automatic logic [COUNT_W-1:0] business_days_between(input date_pair_type p,
                                                                input logic [MASK_W-1:0] mask);
      int     sd, sm, sy, ed, em, ey;
      int     s0, s1, span, wd, per_week, k;
      longint total;
      clamp_date(p.first_date, sd, sm, sy);
      clamp_date(p.finish_date, ed, em, ey);
      s0    = day_number(sd, sm, sy);
      s1    = day_number(ed, em, ey);
      total = 0;
      if (s0 < s1) begin
         span     = s1 - s0;
         per_week = 0;
         for (k = 0; k < 7; k++)
            if (!mask[k]) per_week++;
         total = longint'(span / 7) * per_week;
         wd    = weekday_of(sd, sm, sy);
         // part week walked one day at a time
         for (k = 0; k < span % 7; k++) begin
            if (!mask[wd]) total++;
            wd = (wd + 1) % 7;
         end
         if (total > COUNT_MAX) total = COUNT_MAX;
      end
      return total[COUNT_W-1:0];
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic int idle_gap();
      int r;
      if (!idling_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic date_pair_type make_pair(input int sd, input int sm, input int sy,
                                               input int ed, input int em, input int ey);
      date_pair_type p;
      p.first_date.day    = sd[DAY_W-1:0];
      p.first_date.month  = sm[MONTH_W-1:0];
      p.first_date.year   = sy[YEAR_W-1:0];
      p.finish_date.day   = ed[DAY_W-1:0];
      p.finish_date.month = em[MONTH_W-1:0];
      p.finish_date.year  = ey[YEAR_W-1:0];
      return p;
   endfunction

   function automatic raw_date_type random_valid_date(input int ylo, input int yhi);
      raw_date_type r;
      int           y, m;
      y = $urandom_range(ylo, yhi);
      m = $urandom_range(1, 12);
      r.year  = y[YEAR_W-1:0];
      r.month = m[MONTH_W-1:0];
      r.day   = DAY_W'($urandom_range(1, month_length(m, y)));
      return r;
   endfunction

   function automatic date_pair_type random_pair();
      date_pair_type p;
      int            mode;
      int            y;
      mode = $urandom_range(0, 99);
      if (mode < 60) begin
         // typical use: end date a few years at most after the start
         p.first_date  = random_valid_date(1, 9999);
         y             = p.first_date.year;
         p.finish_date = random_valid_date(y, (y + 3 > 9999) ? 9999 : y + 3);
      end else if (mode < 75) begin
         p.first_date  = random_valid_date(1, 9999);
         p.finish_date = random_valid_date(1, 9999);
      end else if (mode < 90) begin
         // raw fields, out of range values included
         p.first_date.day    = DAY_W'($urandom_range(0, 31));
         p.first_date.month  = MONTH_W'($urandom_range(0, 15));
         p.first_date.year   = YEAR_W'($urandom_range(0, 16383));
         p.finish_date.day   = DAY_W'($urandom_range(0, 31));
         p.finish_date.month = MONTH_W'($urandom_range(0, 15));
         p.finish_date.year  = YEAR_W'($urandom_range(0, 16383));
      end else begin
         // same month, either order, equal dates now and then
         p.first_date  = random_valid_date(1, 9999);
         p.finish_date = p.first_date;
         p.finish_date.day = DAY_W'($urandom_range(1,
            month_length(p.first_date.month, p.first_date.year)));
      end
      return p;
   endfunction

   task automatic offer_dates(input date_pair_type p);
      int gap;
      gap = idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - $bits(date_pair_type)){1'b0}}, p};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_counts.push_back(business_days_between(p, weekend_bits));
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_counts.size() != 0) @(posedge clock);
   endtask

   task automatic write_weekend_mask(input logic [MASK_W-1:0] m);
      drain_results();
      csr_valid <= 1'b1;
      csr_data  <= m;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      weekend_bits = m;
      csr_valid <= 1'b0;
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_directed_dates();
      int k;
      offer_dates(make_pair(1, 1, 1, 31, 12, 9999));
      offer_dates(make_pair(1, 1, 1, 1, 1, 1));
      offer_dates(make_pair(15, 6, 2024, 14, 6, 2024));
      offer_dates(make_pair(0, 0, 0, 31, 15, 16383));
      offer_dates(make_pair(31, 15, 16383, 0, 0, 0));
      offer_dates(make_pair(29, 2, 2000, 1, 3, 2000));
      offer_dates(make_pair(29, 2, 1900, 1, 3, 1900));
      offer_dates(make_pair(31, 2, 2024, 1, 3, 2024));
      offer_dates(make_pair(31, 4, 2023, 1, 5, 2023));
      offer_dates(make_pair(1, 13, 2023, 1, 1, 2024));
      offer_dates(make_pair(0, 1, 2024, 2, 1, 2024));
      offer_dates(make_pair(1, 1, 2024, 8, 1, 2024));
      // one day from each weekday in turn
      for (k = 0; k < 7; k++)
         offer_dates(make_pair(7 + k, 1, 2024, 8 + k, 1, 2024));
      offer_dates(make_pair(31, 12, 9999, 31, 12, 9999));
      offer_dates(make_pair(28, 2, 9999, 1, 3, 9999));
   endtask

   task automatic test_weekend_mask_extremes();
      logic [MASK_W-1:0] masks[4];
      int                i, k;
      masks = '{7'h00, 7'h7f, 7'h01, 7'h40};
      for (i = 0; i < 4; i++) begin
         write_weekend_mask(masks[i]);
         offer_dates(make_pair(1, 1, 1, 31, 12, 9999));
         for (k = 0; k < 8; k++)
            offer_dates(random_pair());
      end
   endtask

   task automatic test_result_backpressure();
      int k;
      write_weekend_mask(7'h01);
      idling_on = 1'b0;
      holds_asked++;
      // receiver holds off while items keep coming, so the input stalls
      for (k = 0; k < 14; k++)
         offer_dates(random_pair());
      idling_on = 1'b1;
   endtask

   task automatic test_random_dates();
      int phase, k;
      for (phase = 0; phase < 5; phase++) begin
         write_weekend_mask(MASK_W'($urandom_range(0, 127)));
         idling_on = (phase != 2);
         for (k = 0; k < 100; k++)
            offer_dates(random_pair());
      end
      idling_on = 1'b1;
   endtask

   // ---------------------------------------------------------------- result side

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (holds_taken != holds_asked) begin
         holds_taken <= holds_taken + 1;
         hold_left   <= LONG_HOLD;
         rsp_tready  <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!rsp_tready || rsp_tvalid) begin
         rsp_gap = idle_gap();
         if (rsp_gap == 0) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b0;
            stall_left <= rsp_gap - 1;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_counts.size() == 0) begin
            mismatch_count++;
            $display("%0t business_days expected none actual %0d", $time,
                     rsp_tdata[COUNT_W-1:0]);
         end else if (rsp_tdata[COUNT_W-1:0] !== pending_counts[0]) begin
            mismatch_count++;
            $display("%0t business_days expected %0d actual %0d", $time,
                     pending_counts[0], rsp_tdata[COUNT_W-1:0]);
            void'(pending_counts.pop_front());
         end else begin
            void'(pending_counts.pop_front());
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_dates();
      test_weekend_mask_extremes();
      test_result_backpressure();
      test_random_dates();
      drain_results();
      repeat (SETTLE) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_business_day_counter_unit OK");
      end else begin
         $display("tb_business_day_counter_unit NOT OK");
      end
      $finish;
   end

   initial begin
      #(RUN_LIMIT);
      $display("%0t run limit reached", $time);
      $display("tb_business_day_counter_unit NOT OK");
      $finish;
   end

endmodule
